[rtl/ydq_pkg.sv]
// shared types, tables and the dct basis function for the ycc dct quantizer
package ydq_pkg;

  localparam int FRAC_BITS_DEF     = 4;
  localparam int COS_FRAC_BITS_DEF = 14;
  localparam int ROW_FRAC          = 8;
  localparam int ROW_W             = 20;

  // cos(j*pi/16) * 2^30, j = 0..8
  localparam logic [31:0] COS30 [9] = '{
    32'd1073741824, 32'd1053110176, 32'd992008094, 32'd892783698, 32'd759250125,
    32'd596538995, 32'd410903207, 32'd209476638, 32'd0
  };

  localparam logic [7:0] Q_LUMA_ZZ [64] = '{
    8'd16, 8'd11, 8'd12, 8'd14, 8'd12, 8'd10, 8'd16, 8'd14,
    8'd13, 8'd14, 8'd18, 8'd17, 8'd16, 8'd19, 8'd24, 8'd40,
    8'd26, 8'd24, 8'd22, 8'd22, 8'd24, 8'd49, 8'd35, 8'd37,
    8'd29, 8'd40, 8'd58, 8'd51, 8'd61, 8'd60, 8'd57, 8'd51,
    8'd56, 8'd55, 8'd64, 8'd72, 8'd92, 8'd78, 8'd64, 8'd68,
    8'd87, 8'd69, 8'd55, 8'd56, 8'd80, 8'd109, 8'd81, 8'd87,
    8'd95, 8'd98, 8'd103, 8'd104, 8'd103, 8'd62, 8'd77, 8'd113,
    8'd121, 8'd112, 8'd100, 8'd120, 8'd92, 8'd101, 8'd103, 8'd99
  };

  localparam logic [7:0] Q_CHROMA_ZZ [64] = '{
    8'd17, 8'd18, 8'd18, 8'd24, 8'd21, 8'd24, 8'd47, 8'd26,
    8'd26, 8'd47, 8'd99, 8'd66, 8'd56, 8'd66, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
    8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99
  };

  // raster position to zigzag index
  localparam logic [5:0] ZZ_INDEX [64] = '{
    6'd0,  6'd1,  6'd5,  6'd6,  6'd14, 6'd15, 6'd27, 6'd28,
    6'd2,  6'd4,  6'd7,  6'd13, 6'd16, 6'd26, 6'd29, 6'd42,
    6'd3,  6'd8,  6'd12, 6'd17, 6'd25, 6'd30, 6'd41, 6'd43,
    6'd9,  6'd11, 6'd18, 6'd24, 6'd31, 6'd40, 6'd44, 6'd53,
    6'd10, 6'd19, 6'd23, 6'd32, 6'd39, 6'd45, 6'd52, 6'd54,
    6'd20, 6'd22, 6'd33, 6'd38, 6'd46, 6'd51, 6'd55, 6'd60,
    6'd21, 6'd34, 6'd37, 6'd47, 6'd50, 6'd56, 6'd59, 6'd61,
    6'd35, 6'd36, 6'd48, 6'd49, 6'd57, 6'd58, 6'd62, 6'd63
  };

  typedef enum logic [1:0] {
    RP_IDLE,
    RP_READ,
    RP_MAC,
    RP_WRITE
  } rp_state_t;

  typedef enum logic [2:0] {
    CP_IDLE,
    CP_READ,
    CP_MAC,
    CP_QSTART,
    CP_DIV,
    CP_HOLD
  } cp_state_t;

  typedef struct packed {
    logic                 en;
    logic [5:0]           addr;
    logic [3*ROW_W-1:0]   data;
  } rp_wr_t;

  typedef struct packed {
    logic busy;
    logic tile_done;
  } rp_stat_t;

  // s(n) * cos(n*pi*(2k+1)/16) with cosf fraction bits, rounded
  function automatic logic signed [31:0] basis(input logic [2:0] n, input logic [2:0] k,
                                               input int cosf);
    logic [6:0]  prod;
    logic [5:0]  j;
    logic        neg;
    logic [63:0] m;
    prod = 7'(n) * (7'(k) * 7'd2 + 7'd1);
    j    = (n == 3'd0) ? 6'd4 : {1'b0, prod[4:0]};
    neg  = 1'b0;
    if (j > 6'd16) j = 6'd32 - j;
    if (j > 6'd8) begin
      j   = 6'd16 - j;
      neg = 1'b1;
    end
    m = ({32'd0, COS30[j[3:0]]} + (64'd1 << (30 - cosf))) >> (31 - cosf);
    return neg ? -$signed(m[31:0]) : $signed(m[31:0]);
  endfunction

endpackage

[rtl/ydq_qdiv.sv]
// bit-serial divider that scales a column sum by its quantizer step and saturates
module ydq_qdiv #(
  parameter int FRAC_BITS     = ydq_pkg::FRAC_BITS_DEF,
  parameter int COS_FRAC_BITS = ydq_pkg::COS_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [COS_FRAC_BITS+22:0] sum,
  input  logic [7:0]                    q,
  output logic                          done,
  output logic signed [15:0]            coef
);

  localparam int CW = COS_FRAC_BITS + 23;
  localparam int SH = ydq_pkg::ROW_FRAC + COS_FRAC_BITS;
  localparam int NW = CW + FRAC_BITS + 1;
  localparam int RW = 24;

  logic          running;
  logic [3:0]    step;
  logic [RW-1:0] rem;
  logic [RW-1:0] dsr;
  logic [15:0]   quo;
  logic          neg;
  logic          ovf;

  logic [CW-1:0] mag;
  logic [NW-1:0] nsum;
  logic [NW-1:0] nq;

  always_comb begin
    mag  = sum[CW-1] ? CW'(-sum) : CW'(sum);
    nsum = (NW'(mag) << FRAC_BITS) + (NW'(q) << (SH - 1));
    nq   = nsum >> SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && step == 4'd15) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= sum[CW-1];
      ovf  <= nq >= (NW'(q) << 16);
      rem  <= nq[RW-1:0];
      dsr  <= RW'(q) << 15;
      quo  <= '0;
      step <= '0;
    end else if (running) begin
      if (rem >= dsr) begin
        rem <= rem - dsr;
        quo <= {quo[14:0], 1'b1};
      end else begin
        quo <= {quo[14:0], 1'b0};
      end
      dsr  <= dsr >> 1;
      step <= step + 4'd1;
    end
  end

  always_comb begin
    if (neg) begin
      coef = (ovf || quo > 16'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, quo}));
    end else begin
      coef = (ovf || quo > 16'd32767) ? 16'sh7fff : $signed(quo);
    end
  end

endmodule

[rtl/ydq_row_pass.sv]
// color conversion, pixel store and the row dct engine
module ydq_row_pass #(
  parameter int COS_FRAC_BITS = ydq_pkg::COS_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [5:0]        waddr,
  input  logic [23:0]       pixel,
  output ydq_pkg::rp_stat_t stat,
  output ydq_pkg::rp_wr_t   wr
);

  localparam int AW = COS_FRAC_BITS + 12;
  localparam int BW = COS_FRAC_BITS + 1;
  localparam int S  = COS_FRAC_BITS - ydq_pkg::ROW_FRAC;
  localparam int RW = ydq_pkg::ROW_W;
  localparam logic [AW-1:0] HALF    = AW'(1) << (S - 1);
  localparam logic [AW-1:0] POS_MAX = AW'((1 << (RW - 1)) - 1);
  localparam logic [AW-1:0] NEG_MAX = AW'(1 << (RW - 1));

  logic [23:0] mem [64];
  logic [23:0] rdata;
  logic [23:0] ycc;

  ydq_pkg::rp_state_t state, state_next;
  logic [2:0] row;
  logic [2:0] k;
  logic [2:0] wn;
  logic       mac_en;
  logic [2:0] mac_k;
  logic signed [AW-1:0] acc [8][3];
  logic signed [BW-1:0] bas [8];

  // bgr to ycbcr
  logic [7:0]         b, g, r;
  logic [24:0]        ys;
  logic signed [25:0] rs, gs, bs, cbs, crs;

  always_comb begin
    b   = pixel[7:0];
    g   = pixel[15:8];
    r   = pixel[23:16];
    ys  = 25'(r) * 25'd19595 + 25'(g) * 25'd38470 + 25'(b) * 25'd7471 + 25'd32767;
    rs  = $signed({18'd0, r});
    gs  = $signed({18'd0, g});
    bs  = $signed({18'd0, b});
    cbs = rs * (-26'sd11059) + gs * (-26'sd21709) + bs * 26'sd32767 + 26'sd8421376;
    crs = rs * 26'sd32767 + gs * (-26'sd27439) + bs * (-26'sd5329) + 26'sd8421376;
    ycc = {crs[23:16], cbs[23:16], ys[23:16]};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= ycc;
    rdata <= mem[{row, k}];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ydq_pkg::RP_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ydq_pkg::RP_IDLE:  if (wr_en && waddr[2:0] == 3'd7) state_next = ydq_pkg::RP_READ;
      ydq_pkg::RP_READ:  if (k == 3'd7) state_next = ydq_pkg::RP_MAC;
      ydq_pkg::RP_MAC:   state_next = ydq_pkg::RP_WRITE;
      ydq_pkg::RP_WRITE: if (wn == 3'd7) state_next = ydq_pkg::RP_IDLE;
      default:           state_next = ydq_pkg::RP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_en <= 1'b0;
    end else begin
      mac_en <= state == ydq_pkg::RP_READ;
    end
    mac_k <= k;
    if (state == ydq_pkg::RP_IDLE && wr_en) row <= waddr[5:3];
    k  <= (state == ydq_pkg::RP_READ) ? k + 3'd1 : 3'd0;
    wn <= (state == ydq_pkg::RP_WRITE) ? wn + 3'd1 : 3'd0;
  end

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      bas[n] = BW'(ydq_pkg::basis(3'(n), mac_k, COS_FRAC_BITS));
    end
  end

  // eight outputs of the row accumulate in parallel, one pixel per cycle
  always_ff @(posedge clk) begin
    logic signed [AW-1:0] xe;
    logic signed [AW-1:0] be;
    if (mac_en) begin
      for (int n = 0; n < 8; n++) begin
        for (int c = 0; c < 3; c++) begin
          xe = $signed({(AW-8)'(0), rdata[8*c +: 8]});
          be = AW'(bas[n]);
          acc[n][c] <= (mac_k == 3'd0) ? xe * be : acc[n][c] + xe * be;
        end
      end
    end
  end

  // round half away from zero, clamp to the row width
  always_comb begin
    logic signed [AW-1:0] v;
    logic [AW-1:0]        mag;
    logic [AW-1:0]        rnd;
    logic [RW-1:0]        f;
    wr.en   = state == ydq_pkg::RP_WRITE;
    wr.addr = {row, wn};
    wr.data = '0;
    for (int c = 0; c < 3; c++) begin
      v   = acc[wn][c];
      mag = v[AW-1] ? AW'(-v) : AW'(v);
      rnd = (mag + HALF) >> S;
      if (v[AW-1]) f = (rnd > NEG_MAX) ? RW'(NEG_MAX) : RW'(-rnd);
      else         f = (rnd > POS_MAX) ? RW'(POS_MAX) : RW'(rnd);
      wr.data[RW*c +: RW] = f;
    end
  end

  assign stat = {state != ydq_pkg::RP_IDLE,
                 state == ydq_pkg::RP_WRITE && wn == 3'd7 && row == 3'd7};

endmodule

[rtl/ydq_col_pass.sv]
// row result store, column dct, quantizer lanes and the output register
module ydq_col_pass #(
  parameter int FRAC_BITS     = ydq_pkg::FRAC_BITS_DEF,
  parameter int COS_FRAC_BITS = ydq_pkg::COS_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ydq_pkg::rp_wr_t    wr,
  output logic               busy,
  output logic               coef_valid,
  input  logic               coef_stall,
  output logic [5:0]         position,
  output logic signed [15:0] luma_coef,
  output logic signed [15:0] blue_diff_coef,
  output logic signed [15:0] red_diff_coef,
  output logic               last
);

  localparam int CW = COS_FRAC_BITS + 23;
  localparam int BW = COS_FRAC_BITS + 1;
  localparam int RW = ydq_pkg::ROW_W;

  logic [3*RW-1:0] mem [64];
  logic [3*RW-1:0] rdata;

  ydq_pkg::cp_state_t state, state_next;
  logic [5:0] p;
  logic [2:0] rr;
  logic       mac_en;
  logic [2:0] mac_rr;
  logic signed [CW-1:0] acc [3];
  logic signed [BW-1:0] bas;
  logic [7:0] q_luma, q_chroma;
  logic [2:0] dn;
  logic signed [15:0] res [3];
  logic       div_done;
  logic       load;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rdata <= mem[{rr, p[2:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ydq_pkg::CP_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    case (state)
      ydq_pkg::CP_IDLE:   if (start) state_next = ydq_pkg::CP_READ;
      ydq_pkg::CP_READ:   if (rr == 3'd7) state_next = ydq_pkg::CP_MAC;
      ydq_pkg::CP_MAC:    state_next = ydq_pkg::CP_QSTART;
      ydq_pkg::CP_QSTART: state_next = ydq_pkg::CP_DIV;
      ydq_pkg::CP_DIV:    if (div_done) state_next = ydq_pkg::CP_HOLD;
      ydq_pkg::CP_HOLD: begin
        if (!coef_valid || !coef_stall) begin
          load       = 1'b1;
          state_next = (p == 6'd63) ? ydq_pkg::CP_IDLE : ydq_pkg::CP_READ;
        end
      end
      default:            state_next = ydq_pkg::CP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mac_en <= 1'b0;
    end else begin
      mac_en <= state == ydq_pkg::CP_READ;
    end
    mac_rr <= rr;
    rr     <= (state == ydq_pkg::CP_READ) ? rr + 3'd1 : 3'd0;
    if (state == ydq_pkg::CP_IDLE) p <= '0;
    else if (load)                 p <= p + 6'd1;
  end

  assign bas = BW'(ydq_pkg::basis(p[5:3], mac_rr, COS_FRAC_BITS));

  // row value times basis at its own width, then sign extended into the sum
  always_ff @(posedge clk) begin
    logic signed [RW+BW-1:0] pr;
    if (mac_en) begin
      for (int c = 0; c < 3; c++) begin
        pr = $signed(rdata[RW*c +: RW]) * bas;
        acc[c] <= (mac_rr == 3'd0) ? CW'(pr) : acc[c] + CW'(pr);
      end
    end
  end

  // steps are stored in zigzag order
  assign q_luma   = ydq_pkg::Q_LUMA_ZZ[ydq_pkg::ZZ_INDEX[p]];
  assign q_chroma = ydq_pkg::Q_CHROMA_ZZ[ydq_pkg::ZZ_INDEX[p]];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    ydq_qdiv #(
      .FRAC_BITS    (FRAC_BITS),
      .COS_FRAC_BITS(COS_FRAC_BITS)
    ) u_qdiv (
      .clk  (clk),
      .rst  (rst),
      .start(state == ydq_pkg::CP_QSTART),
      .sum  (acc[c]),
      .q    ((c == 0) ? q_luma : q_chroma),
      .done (dn[c]),
      .coef (res[c])
    );
  end

  assign div_done = &dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_valid <= 1'b0;
    end else if (load) begin
      coef_valid <= 1'b1;
    end else if (!coef_stall) begin
      coef_valid <= 1'b0;
    end
    if (load) begin
      position       <= p;
      luma_coef      <= res[0];
      blue_diff_coef <= res[1];
      red_diff_coef  <= res[2];
      last           <= p == 6'd63;
    end
  end

  assign busy = state != ydq_pkg::CP_IDLE;

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    coef_valid && last |-> position == 6'd63)
    else $error("last beat not at position 63");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ydq_pkg::CP_DIV)
    else $error("quantizer finished outside the divide state");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    coef_valid && !coef_stall && !load |=> !coef_valid)
    else $error("output beat repeated");

endmodule

[rtl/ycc_dct8x8_quantizer.sv]
// top level: pixel counter and sequencing of the row and column passes
// Takes the 64 BGR pixels of an 8x8 tile in raster order and returns 64 quantized
// Y/Cb/Cr coefficients in raster order, the last flagged. Pixels within a row are
// taken one per cycle; the eighth pixel of each row starts a row pass (8 reads of
// the pixel memory into 24 parallel multiply-accumulators, a drain state, 8 writes
// to the row memory) during which pixel_stall is high. The 64th pixel is followed
// by the column pass, which is stalled on the input side until the last coefficient
// is in the output register: each coefficient comes from 8 reads of the row memory
// through 3 multiply-accumulators, then a 16-step bit-serial division by the
// quantizer step in 3 lanes. The memories are not cleared after reset; every entry
// is written by a tile before it is read.
module ycc_dct8x8_quantizer #(
  parameter int FRAC_BITS     = ydq_pkg::FRAC_BITS_DEF,
  parameter int COS_FRAC_BITS = ydq_pkg::COS_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  logic [23:0]        pixel,
  output logic               coef_valid,
  input  logic               coef_stall,
  output logic [5:0]         position,
  output logic signed [15:0] luma_coef,
  output logic signed [15:0] blue_diff_coef,
  output logic signed [15:0] red_diff_coef,
  output logic               last
);

  logic              pix_accept;
  logic [5:0]        pixel_count;
  logic              cp_busy;
  ydq_pkg::rp_stat_t rp_stat;
  ydq_pkg::rp_wr_t   rp_wr;

  assign pixel_stall = rp_stat.busy || cp_busy;
  assign pix_accept  = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst)             pixel_count <= '0;
    else if (pix_accept) pixel_count <= pixel_count + 6'd1;
  end

  ydq_row_pass #(
    .COS_FRAC_BITS(COS_FRAC_BITS)
  ) u_row_pass (
    .clk  (clk),
    .rst  (rst),
    .wr_en(pix_accept),
    .waddr(pixel_count),
    .pixel(pixel),
    .stat (rp_stat),
    .wr   (rp_wr)
  );

  ydq_col_pass #(
    .FRAC_BITS    (FRAC_BITS),
    .COS_FRAC_BITS(COS_FRAC_BITS)
  ) u_col_pass (
    .clk           (clk),
    .rst           (rst),
    .start         (rp_stat.tile_done),
    .wr            (rp_wr),
    .busy          (cp_busy),
    .coef_valid    (coef_valid),
    .coef_stall    (coef_stall),
    .position      (position),
    .luma_coef     (luma_coef),
    .blue_diff_coef(blue_diff_coef),
    .red_diff_coef (red_diff_coef),
    .last          (last)
  );

  a_one_pass: assert property (@(posedge clk) disable iff (rst)
    !(rp_stat.busy && cp_busy))
    else $error("row and column passes overlap");

  a_tile_wrap: assert property (@(posedge clk) disable iff (rst)
    rp_stat.tile_done |-> pixel_count == 6'd0)
    else $error("column pass started mid tile");

  a_row_start: assert property (@(posedge clk) disable iff (rst)
    pix_accept && pixel_count[2:0] == 3'd7 |=> rp_stat.busy)
    else $error("row pass did not start after a full row");

endmodule
